>>> rtl/rlebd_pkg.sv
// Shared types and constants for the bilevel run-length decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package rlebd_pkg;

  localparam int CFG_ADDR_BITS = 2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_BITS-1:0] REG_ORIGIN_X     = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ORIGIN_Y     = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_HEIGHT = 2'd3;

  // Input item kinds carried in tuser.
  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_SYMBOL = 1'b1;

  // Colors.
  localparam logic COLOR_WHITE = 1'b0;

  // Status of the descriptor queue as seen by its two sides.
  typedef struct packed {
    logic full;
    logic empty;
  } rlebd_qstat_t;

endpackage

>>> rtl/rlebd_front.sv
// Front end of the decoder: accepts input items, keeps the run state and
// produces one run descriptor per emitted run. Depends on rlebd_pkg.
module rlebd_front
  import rlebd_pkg::*;
#(
  parameter int SYMBOL_BITS = 4,
  parameter int COORD_BITS  = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_action,
  input  logic [SYMBOL_BITS-1:0]     in_symbol,
  input  logic [COORD_BITS-1:0]      image_width,
  input  logic [COORD_BITS-1:0]      image_height,
  input  rlebd_qstat_t               qstat,
  output logic                       q_push,
  output logic [4*COORD_BITS+1:0]    q_data
);

  localparam int OFF_W = 2 * COORD_BITS;
  localparam int MUL_W = OFF_W + SYMBOL_BITS + 1;
  localparam logic [SYMBOL_BITS-1:0] SEP_CODE = {SYMBOL_BITS{1'b1}};

  typedef enum logic [2:0] {F_IDLE, F_SIZE, F_ACC, F_EVAL, F_PUSH} fstate_t;

  fstate_t                state_r;
  logic                   action_r;
  logic [SYMBOL_BITS-1:0] sym_r;
  logic [OFF_W-1:0]       size_r;
  logic [OFF_W-1:0]       off_r;
  logic [OFF_W-1:0]       acc_r;
  logic                   color_r;
  logic                   done_r;
  logic [OFF_W-1:0]       d_off_r;
  logic [OFF_W-1:0]       d_len_r;
  logic                   d_color_r;
  logic                   d_last_r;

  logic [MUL_W-1:0] acc_mul;
  logic [OFF_W-1:0] acc_clamp;
  logic [OFF_W:0]   total;
  logic             total_hit;

  // acc * (2^SYMBOL_BITS - 1) + digit, as a shift and a subtract.
  assign acc_mul   = (MUL_W'(acc_r) << SYMBOL_BITS) - MUL_W'(acc_r) + MUL_W'(sym_r);
  assign acc_clamp = (acc_mul > MUL_W'(size_r)) ? size_r : acc_mul[OFF_W-1:0];
  assign total     = {1'b0, off_r} + {1'b0, acc_r};
  assign total_hit = total >= {1'b0, size_r};

  assign in_ready = (state_r == F_IDLE);
  assign q_push   = (state_r == F_PUSH) && !qstat.full;
  assign q_data   = {d_last_r, d_color_r, d_len_r, d_off_r};

  always_ff @(posedge clk) begin
    // The image size follows the registers through size_r; F_SIZE lets it settle.
    size_r <= OFF_W'(image_width * image_height);
    if (!rst_n) begin
      state_r <= F_IDLE;
      off_r   <= '0;
      acc_r   <= '0;
      color_r <= COLOR_WHITE;
      done_r  <= 1'b1;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            action_r <= in_action;
            sym_r    <= in_symbol;
            state_r  <= F_SIZE;
          end
        end
        F_SIZE: begin
          state_r <= F_ACC;
        end
        F_ACC: begin
          if (action_r == ACT_START) begin
            off_r   <= '0;
            acc_r   <= '0;
            color_r <= COLOR_WHITE;
            if (size_r == '0) begin
              // Empty image: a single zero-length final run.
              done_r    <= 1'b1;
              d_off_r   <= '0;
              d_len_r   <= '0;
              d_color_r <= COLOR_WHITE;
              d_last_r  <= 1'b1;
              state_r   <= F_PUSH;
            end else begin
              done_r  <= 1'b0;
              state_r <= F_IDLE;
            end
          end else if (done_r) begin
            state_r <= F_IDLE;
          end else if (off_r >= size_r) begin
            // The image shrank under the current offset.
            done_r    <= 1'b1;
            d_off_r   <= off_r;
            d_len_r   <= '0;
            d_color_r <= color_r;
            d_last_r  <= 1'b1;
            state_r   <= F_PUSH;
          end else begin
            if (sym_r != SEP_CODE) begin
              acc_r <= acc_clamp;
            end
            state_r <= F_EVAL;
          end
        end
        F_EVAL: begin
          if (total_hit) begin
            done_r    <= 1'b1;
            d_off_r   <= off_r;
            d_len_r   <= size_r - off_r;
            d_color_r <= color_r;
            d_last_r  <= 1'b1;
            state_r   <= F_PUSH;
          end else if (sym_r == SEP_CODE) begin
            d_off_r   <= off_r;
            d_len_r   <= acc_r;
            d_color_r <= color_r;
            d_last_r  <= 1'b0;
            off_r     <= total[OFF_W-1:0];
            acc_r     <= '0;
            color_r   <= ~color_r;
            state_r   <= F_PUSH;
          end else begin
            state_r <= F_IDLE;
          end
        end
        F_PUSH: begin
          if (!qstat.full) begin
            state_r <= F_IDLE;
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/rlebd_queue.sv
// Small first-in first-out queue of run descriptors between front and back.
// Depends on rlebd_pkg for the status struct.
module rlebd_queue
  import rlebd_pkg::*;
#(
  parameter int WIDTH = 42,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output rlebd_qstat_t     qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign pop_data    = mem_r[rd_ptr_r];
  assign qstat.full  = (count_r == CNT_W'(DEPTH));
  assign qstat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/rlebd_back.sv
// Back end of the decoder: takes run descriptors, divides the offset by the
// image width one bit per cycle and holds the result item. Uses rlebd_pkg.
module rlebd_back
  import rlebd_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rlebd_qstat_t             qstat,
  input  logic [4*COORD_BITS+1:0]  q_data,
  output logic                     q_pop,
  input  logic [COORD_BITS-1:0]    origin_x,
  input  logic [COORD_BITS-1:0]    origin_y,
  input  logic [COORD_BITS-1:0]    image_width,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [COORD_BITS:0]      out_col,
  output logic [COORD_BITS:0]      out_row,
  output logic [2*COORD_BITS-1:0]  out_off,
  output logic [2*COORD_BITS-1:0]  out_len,
  output logic                     out_color,
  output logic                     out_last
);

  localparam int OFF_W = 2 * COORD_BITS;
  localparam int CNT_W = $clog2(OFF_W + 1);

  typedef enum logic [1:0] {B_IDLE, B_DIV, B_OUT} bstate_t;

  bstate_t               state_r;
  logic [OFF_W-1:0]      off_r;
  logic [OFF_W-1:0]      len_r;
  logic                  color_r;
  logic                  last_r;
  logic [COORD_BITS-1:0] rem_r;
  logic [OFF_W-1:0]      quo_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  out_valid_r;

  logic [COORD_BITS:0]   trial;
  logic                  trial_ge;
  logic [COORD_BITS:0]   trial_sub;

  // Restoring division: bring down one dividend bit per cycle.
  assign trial     = {rem_r, quo_r[OFF_W-1]};
  assign trial_ge  = trial >= {1'b0, image_width};
  assign trial_sub = trial - {1'b0, image_width};

  assign q_pop     = (state_r == B_IDLE) && !qstat.empty;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == B_OUT) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (!qstat.empty) begin
            off_r   <= q_data[OFF_W-1:0];
            len_r   <= q_data[2*OFF_W-1:OFF_W];
            color_r <= q_data[2*OFF_W];
            last_r  <= q_data[2*OFF_W+1];
            rem_r   <= '0;
            cnt_r   <= '0;
            if (image_width == '0) begin
              // Zero width places the run at the origin.
              quo_r   <= '0;
              state_r <= B_OUT;
            end else begin
              quo_r   <= q_data[OFF_W-1:0];
              state_r <= B_DIV;
            end
          end
        end
        B_DIV: begin
          rem_r <= trial_ge ? trial_sub[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
          quo_r <= {quo_r[OFF_W-2:0], trial_ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(OFF_W - 1)) begin
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_col     <= {1'b0, origin_x} + {1'b0, rem_r};
            out_row     <= {1'b0, origin_y} + quo_r[COORD_BITS:0];
            out_off     <= off_r;
            out_len     <= len_r;
            out_color   <= color_r;
            out_last    <= last_r;
            state_r     <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/rle_bilevel_run_decoder_unit.sv
// Top level of the bilevel run-length image decoder: configuration registers,
// front end, descriptor queue and back end. Depends on rlebd_pkg.
//
// Usage. The input stream carries one item per code: in_tuser[0] is the kind
// (0 starts a new image, 1 delivers a symbol) and in_tdata holds the symbol.
// The all-ones symbol closes the current run; any other symbol appends a
// digit to the run length. Each closed run leaves as one item on the out_
// stream with its start column, row, linear offset, length and color;
// out_tlast marks the run that completes the image. The user must write origin
// and size through the cfg_ write port only while no item is in flight; the
// decoder itself does not enforce this. Timing. The front end takes one item
// at a time and returns to idle before it accepts the next; a symbol that
// closes a run first pushes its descriptor. In the back end each run then goes
// through the bit-serial divide of the offset by the image width before its
// result is registered. A two-entry queue lets the front end keep taking items
// while the back end divides or while out_tready is low; when the queue is
// full and the front end has a run to push, in_tready stays low. A finished
// result waits in the output register until it is taken. Reset (rst_n low,
// synchronous) clears the configuration registers to zero and leaves the
// decoder idle: symbols are ignored until a start item.
module rle_bilevel_run_decoder_unit
  import rlebd_pkg::*;
#(
  parameter int SYMBOL_BITS = 4,
  parameter int COORD_BITS  = 10
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // in_tdata fields, lowest bit up: symbol
  input  logic [((SYMBOL_BITS+7)/8)*8-1:0]        in_tdata,
  // in_tuser fields, lowest bit up: action
  input  logic [0:0]                              in_tuser,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // out_tdata fields, lowest bit up: run_start_col, run_start_row,
  // run_offset, run_length, run_color
  output logic [((6*COORD_BITS+3+7)/8)*8-1:0]     out_tdata,
  output logic                                    out_tlast,
  input  logic                                    cfg_we,
  input  logic [CFG_ADDR_BITS-1:0]                cfg_addr,
  input  logic [COORD_BITS-1:0]                   cfg_wdata
);

  localparam int OFF_W    = 2 * COORD_BITS;
  localparam int DESC_W   = 2 * OFF_W + 2;
  localparam int OUT_W    = ((6 * COORD_BITS + 3 + 7) / 8) * 8;
  localparam int FIELDS_W = 6 * COORD_BITS + 3;
  localparam int Q_DEPTH  = 2;

  logic [COORD_BITS-1:0] origin_x_r;
  logic [COORD_BITS-1:0] origin_y_r;
  logic [COORD_BITS-1:0] width_r;
  logic [COORD_BITS-1:0] height_r;

  rlebd_qstat_t      qstat;
  logic              q_push;
  logic              q_pop;
  logic [DESC_W-1:0] q_wdata;
  logic [DESC_W-1:0] q_rdata;

  logic [COORD_BITS:0] col;
  logic [COORD_BITS:0] row;
  logic [OFF_W-1:0]    off;
  logic [OFF_W-1:0]    len;
  logic                color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      width_r    <= '0;
      height_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ORIGIN_X:     origin_x_r <= cfg_wdata;
        REG_ORIGIN_Y:     origin_y_r <= cfg_wdata;
        REG_IMAGE_WIDTH:  width_r    <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  rlebd_front #(
    .SYMBOL_BITS (SYMBOL_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_action    (in_tuser[0]),
    .in_symbol    (in_tdata[SYMBOL_BITS-1:0]),
    .image_width  (width_r),
    .image_height (height_r),
    .qstat        (qstat),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  rlebd_queue #(
    .WIDTH (DESC_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .qstat     (qstat)
  );

  rlebd_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .qstat       (qstat),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .origin_x    (origin_x_r),
    .origin_y    (origin_y_r),
    .image_width (width_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_col     (col),
    .out_row     (row),
    .out_off     (off),
    .out_len     (len),
    .out_color   (color),
    .out_last    (out_tlast)
  );

  assign out_tdata = {{(OUT_W - FIELDS_W){1'b0}}, color, len, off, row, col};

  // The front end only pushes when the queue has room.
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !qstat.full)
    else $error("descriptor pushed into a full queue");

  // The back end only pops a descriptor that is there.
  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !qstat.empty)
    else $error("descriptor popped from an empty queue");

  // A new result's column lies within the image when the width is nonzero.
  a_col_in_image : assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_tvalid) && (width_r != '0)) |->
      ((col - {1'b0, origin_x_r}) < {1'b0, width_r}))
    else $error("run start column outside the image");

endmodule

>>> dv/rle_bilevel_run_decoder_unit_tb.sv
// Self-checking testbench for the bilevel run-length decoder: a directed script,
// then random images under random origins and sizes, checked against a predictor.
// Depends on rlebd_pkg and rle_bilevel_run_decoder_unit.
module rle_bilevel_run_decoder_unit_tb
  import rlebd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1100;
  localparam int TAIL_CYCLES = 64;
  localparam int STALL_LIMIT = 3000;
  localparam logic [3:0] SYM_SEP = 4'hF;

  typedef struct packed {
    logic [10:0] col;
    logic [10:0] row;
    logic [19:0] off;
    logic [19:0] len;
    logic        color;
    logic        fin;
  } run_t;

  typedef struct packed {
    logic       is_cfg;
    logic [9:0] ox;
    logic [9:0] oy;
    logic [9:0] w;
    logic [9:0] h;
    logic       act;
    logic [3:0] sym;
    logic       typed;
    run_t       want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [9:0]  cfg_wdata = '0;

  // Predictor copy of the registers and the decoder state.
  logic [9:0]  org_x = '0;
  logic [9:0]  org_y = '0;
  logic [9:0]  img_w = '0;
  logic [9:0]  img_h = '0;
  logic [19:0] cur_off = '0;
  logic [19:0] len_acc = '0;
  logic        ink = COLOR_WHITE;
  bit          drawing = 1'b0;

  run_t        runs_due[$];
  script_row_t script[$];
  int          fails = 0;
  int          useful_items = 0;
  int          calm_items = 0;
  int          idle_cycles = 0;

  rle_bilevel_run_decoder_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned img_area();
    return 64'(img_w) * 64'(img_h);
  endfunction

  function automatic run_t make_run(input longint unsigned off, input longint unsigned len,
                                    input logic color, input logic fin);
    run_t r;
    longint unsigned col, row;
    col = 64'(org_x);
    row = 64'(org_y);
    if (img_w != 0) begin
      col += off % img_w;
      row += off / img_w;
    end
    r.col = col[10:0];
    r.row = row[10:0];
    r.off = off[19:0];
    r.len = len[19:0];
    r.color = color;
    r.fin = fin;
    return r;
  endfunction

  // Returns 1 when the item closes a run; counted is 0 for items the decoder ignores.
  function automatic bit decode_item(input logic act, input logic [3:0] sym,
                                     output run_t run, output bit counted);
    longint unsigned area, grown, reach;
    area = img_area();
    run = '0;
    counted = 1'b1;
    if (act == ACT_START) begin
      cur_off = '0;
      len_acc = '0;
      ink = COLOR_WHITE;
      drawing = 1'b1;
      if (area == 0) begin
        drawing = 1'b0;
        run = make_run(64'd0, 64'd0, COLOR_WHITE, 1'b1);
        return 1'b1;
      end
      return 1'b0;
    end
    if (!drawing) begin
      counted = 1'b0;
      return 1'b0;
    end
    // The image may have shrunk below the current offset through a register write.
    if (64'(cur_off) >= area) begin
      drawing = 1'b0;
      run = make_run(64'(cur_off), 64'd0, ink, 1'b1);
      return 1'b1;
    end
    if (sym != SYM_SEP) begin
      grown = 64'(len_acc) * 15 + 64'(sym);
      len_acc = (grown > area) ? area[19:0] : grown[19:0];
    end
    reach = 64'(cur_off) + 64'(len_acc);
    if (reach >= area) begin
      drawing = 1'b0;
      run = make_run(64'(cur_off), area - 64'(cur_off), ink, 1'b1);
      return 1'b1;
    end
    if (sym == SYM_SEP) begin
      run = make_run(64'(cur_off), 64'(len_acc), ink, 1'b0);
      cur_off = cur_off + len_acc;
      len_acc = '0;
      ink = ~ink;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int digit_span(input longint unsigned area);
    int n;
    longint unsigned span;
    n = 1;
    span = 15;
    while (span <= area) begin
      span *= 15;
      n++;
    end
    return n;
  endfunction

  function automatic int next_gap();
    int r;
    if (calm_items != 0) begin
      calm_items--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm_items = $urandom_range(20, 60);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [9:0] pick_origin();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return 10'($urandom_range(0, 1023));
  endfunction

  function automatic string show_run(input run_t r);
    return $sformatf("col=%0d row=%0d off=%0d len=%0d color=%0b last=%0b",
                     r.col, r.row, r.off, r.len, r.color, r.fin);
  endfunction

  task automatic count_fail(input string msg);
    fails++;
    if (fails <= 10) $display("%s", msg);
  endtask

  function automatic void add_item(input logic act, input logic [3:0] sym);
    script_row_t r;
    r = '0;
    r.act = act;
    r.sym = sym;
    script.push_back(r);
  endfunction

  function automatic void add_check(input logic act, input logic [3:0] sym, input run_t want);
    script_row_t r;
    r = '0;
    r.act = act;
    r.sym = sym;
    r.typed = 1'b1;
    r.want = want;
    script.push_back(r);
  endfunction

  function automatic void add_cfg(input logic [9:0] ox, input logic [9:0] oy,
                                  input logic [9:0] w, input logic [9:0] h);
    script_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.ox = ox;
    r.oy = oy;
    r.w = w;
    r.h = h;
    script.push_back(r);
  endfunction

  // Offers one item after a random gap and predicts its run once it is taken.
  task automatic send_item(input logic act, input logic [3:0] sym,
                           input bit typed, input run_t want);
    int gap;
    run_t run;
    bit closes, counted;
    gap = next_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= {4'b0000, sym};
    do @(posedge clk); while (!in_tready);
    closes = decode_item(act, sym, run, counted);
    if (typed) runs_due.push_back(want);
    else if (closes) runs_due.push_back(run);
    if (counted) useful_items++;
  endtask

  // Drains every expected run, then lets the decoder finish any item still inside.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (runs_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic [9:0] ox, input logic [9:0] oy,
                             input logic [9:0] w, input logic [9:0] h);
    logic [CFG_ADDR_BITS-1:0] addrs [4];
    logic [9:0] vals [4];
    addrs = '{REG_ORIGIN_X, REG_ORIGIN_Y, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT};
    vals = '{ox, oy, w, h};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= addrs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    org_x = ox;
    org_y = oy;
    img_w = w;
    img_h = h;
  endtask

  // Mostly well-formed runs with random digits, mixed with stray symbols,
  // aborting starts and symbols sent while the decoder is idle.
  task automatic image_burst(input int quota);
    int first, nd, r;
    first = useful_items;
    while (useful_items - first < quota) begin
      r = $urandom_range(0, 99);
      if (!drawing) begin
        if (r < 10) send_item(ACT_SYMBOL, 4'($urandom_range(0, 15)), 1'b0, '0);
        else send_item(ACT_START, 4'($urandom_range(0, 15)), 1'b0, '0);
      end else if (r < 4) begin
        send_item(ACT_START, 4'($urandom_range(0, 15)), 1'b0, '0);
      end else if (r < 14) begin
        send_item(ACT_SYMBOL, 4'($urandom_range(0, 15)), 1'b0, '0);
      end else begin
        nd = $urandom_range(0, digit_span(img_area()));
        repeat (nd) begin
          if (drawing) send_item(ACT_SYMBOL, 4'($urandom_range(0, 14)), 1'b0, '0);
        end
        if (drawing) send_item(ACT_SYMBOL, SYM_SEP, 1'b0, '0);
      end
    end
  endtask

  initial begin : stimulus
    int r;
    logic [9:0] w, h;

    add_item(ACT_SYMBOL, SYM_SEP);
    add_check(ACT_START, 4'h0, {11'd0, 11'd0, 20'd0, 20'd0, COLOR_WHITE, 1'b1});
    add_cfg(10'd1023, 10'd1023, 10'd0, 10'd5);
    add_check(ACT_START, 4'h0, {11'd1023, 11'd1023, 20'd0, 20'd0, COLOR_WHITE, 1'b1});
    add_cfg(10'd3, 10'd2, 10'd4, 10'd3);
    add_item(ACT_START, 4'h0);
    add_item(ACT_SYMBOL, 4'h2);
    add_check(ACT_SYMBOL, SYM_SEP, {11'd3, 11'd2, 20'd0, 20'd2, COLOR_WHITE, 1'b0});
    add_item(ACT_SYMBOL, 4'h0);
    add_item(ACT_SYMBOL, SYM_SEP);
    add_item(ACT_SYMBOL, 4'h1);
    add_item(ACT_SYMBOL, 4'h3);
    add_item(ACT_SYMBOL, SYM_SEP);
    add_item(ACT_START, 4'h0);
    add_item(ACT_SYMBOL, 4'h5);
    add_item(ACT_START, 4'h0);
    add_item(ACT_SYMBOL, 4'h6);
    add_item(ACT_SYMBOL, SYM_SEP);
    // Shrink the image below the current offset while it is half drawn.
    add_cfg(10'd3, 10'd2, 10'd2, 10'd2);
    add_item(ACT_SYMBOL, 4'h9);
    add_cfg(10'd3, 10'd2, 10'd4, 10'd3);
    add_item(ACT_START, 4'h0);
    add_item(ACT_SYMBOL, 4'hC);
    add_item(ACT_SYMBOL, SYM_SEP);
    add_cfg(10'd0, 10'd0, 10'd1023, 10'd1023);
    add_item(ACT_START, 4'h0);
    repeat (6) add_item(ACT_SYMBOL, 4'hE);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        load_config(script[i].ox, script[i].oy, script[i].w, script[i].h);
      end else begin
        send_item(script[i].act, script[i].sym, script[i].typed, script[i].want);
      end
    end

    while (useful_items < ITEM_TARGET) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 55) begin
        w = 10'($urandom_range(1, 16));
        h = 10'($urandom_range(1, 16));
      end else if (r < 67) begin
        w = 10'($urandom_range(1, 1023));
        h = 10'($urandom_range(1, 4));
      end else if (r < 77) begin
        w = 10'($urandom_range(1, 4));
        h = 10'($urandom_range(1, 1023));
      end else if (r < 81) begin
        w = '0;
        h = 10'($urandom_range(0, 1023));
      end else if (r < 85) begin
        w = 10'($urandom_range(0, 1023));
        h = '0;
      end else if (r < 95) begin
        w = 10'($urandom_range(1, 64));
        h = 10'($urandom_range(1, 64));
      end else begin
        w = '1;
        h = '1;
      end
      load_config(pick_origin(), pick_origin(), w, h);
      image_burst($urandom_range(15, 80));
    end

    settle();
    if (runs_due.size() != 0)
      count_fail($sformatf("%0d runs never arrived", runs_due.size()));
    if (fails == 0) begin
      $display("rle_bilevel_run_decoder_unit_tb OK");
    end else begin
      $display("rle_bilevel_run_decoder_unit_tb NOT OK");
    end
    $finish;
  end

  // Result side: checks each taken run and paces out_tready, including two long
  // hold-offs that fill the queue and push back on the input.
  always @(posedge clk) begin : sink
    run_t got, want;
    int r;
    int hold_left;
    int calm_left;
    int taken;
    logic ready_next;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[10:0], out_tdata[21:11], out_tdata[41:22], out_tdata[61:42],
             out_tdata[62], out_tlast};
      if (runs_due.size() == 0) begin
        count_fail($sformatf("unexpected run: %s", show_run(got)));
      end else begin
        want = runs_due.pop_front();
        if (got !== want)
          count_fail($sformatf("run mismatch: want %s / got %s", show_run(want), show_run(got)));
      end
      taken++;
      if (taken == 100 || taken == 300) hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else if (calm_left > 0) begin
      calm_left--;
      ready_next = 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) calm_left = $urandom_range(50, 200);
      else if (r < 5) hold_left = $urandom_range(20, 80);
      else if (r < 30) hold_left = $urandom_range(1, 4);
      ready_next = (hold_left == 0);
    end
    out_tready <= ready_next;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("rle_bilevel_run_decoder_unit_tb NOT OK");
        $finish;
      end
    end
  end

endmodule
